[hw/rtl/lesf_pkg.sv]
package lesf_pkg;

  // Default grid limits
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Fixed field widths
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned GW_W       = 11;
  localparam int unsigned SIZE_OUT_W = 11;
  localparam int unsigned POS_OUT_W  = 10;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] OBST_RESET   = 8'd111;
  localparam logic [GW_W-1:0]   GW_RESET     = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBSTACLE = 1'b0,
    CFG_WIDTH    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SIZE_OUT_W-1:0] size;
    logic [POS_OUT_W-1:0]  row;
    logic [POS_OUT_W-1:0]  col;
  } res_t;

endpackage

[hw/rtl/lesf_ram.sv]
module lesf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lesf_pos.sv]
module lesf_pos import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            last_i,
  input  logic [GW_W-1:0] grid_width_i,
  output logic [CW-1:0]   col_o,
  output logic [RW-1:0]   row_o
);

  logic [CW-1:0] col_count_q, col_count_d;
  logic [RW-1:0] row_count_q, row_count_d;
  logic [WW-1:0] width_eff;
  logic          wrap_pre;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur, row_cur_inc, row_pre_inc;

  // clamp width to 1..MAX_WIDTH
  always_comb begin
    if (grid_width_i == '0) begin
      width_eff = WW'(1);
    end else if (32'(grid_width_i) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(grid_width_i);
    end
  end

  // saturating row increments
  assign row_pre_inc = (32'(row_count_q) < MAX_HEIGHT) ? row_count_q + RW'(1) : row_count_q;
  assign wrap_pre    = 32'(col_count_q) >= 32'(width_eff);
  assign col_cur     = wrap_pre ? '0 : col_count_q;
  assign row_cur     = wrap_pre ? row_pre_inc : row_count_q;
  assign row_cur_inc = (32'(row_cur) < MAX_HEIGHT) ? row_cur + RW'(1) : row_cur;

  always_comb begin
    if (last_i) begin
      col_count_d = '0;
      row_count_d = '0;
    end else if (32'(col_cur) + 32'd1 >= 32'(width_eff)) begin
      col_count_d = '0;
      row_count_d = row_cur_inc;
    end else begin
      col_count_d = col_cur + CW'(1);
      row_count_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (advance_i) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  assign col_o = col_cur;
  assign row_o = row_cur;

endmodule

[hw/rtl/lesf_dp.sv]
module lesf_dp import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned MW = ((SW > RW) ? SW : RW) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  input  logic          blocked_i,
  input  logic          last_i,
  input  logic [SW-1:0] ram_data_i,
  input  logic          fwd_i,
  input  logic [SW-1:0] fwd_data_i,
  input  logic          hit_i,
  output logic [SW-1:0] size_o,
  output logic          push_o,
  output res_t          res_o
);

  logic [SW-1:0] left_q, diag_q;
  logic [SW-1:0] best_len_q, best_len_nxt;
  logic [RW-1:0] best_r_q, best_r_nxt;
  logic [CW-1:0] best_c_q, best_c_nxt;
  logic [SW-1:0] up_mem, up, left_eff, diag_eff, m1, m2, size;
  logic [MW-1:0] cand, cap_r, cap_c, s_a, s_b;
  logic          larger;

  // up: forwarded write, else buffer entry if ever written, else zero
  assign up_mem   = fwd_i ? fwd_data_i : (hit_i ? ram_data_i : '0);
  assign up       = (row_i == '0) ? '0 : up_mem;
  assign left_eff = (col_i == '0) ? '0 : left_q;
  assign diag_eff = (col_i == '0) ? '0 : diag_q;

  assign m1    = (up < left_eff) ? up : left_eff;
  assign m2    = (m1 < diag_eff) ? m1 : diag_eff;
  assign cand  = MW'(m2) + MW'(1);
  assign cap_r = MW'(row_i) + MW'(1);
  assign cap_c = MW'(col_i) + MW'(1);
  assign s_a   = (cand < cap_r) ? cand : cap_r;
  assign s_b   = (s_a < cap_c) ? s_a : cap_c;
  assign size  = blocked_i ? '0 : SW'(s_b);

  // strict compare keeps the first square on ties
  assign larger       = size > best_len_q;
  assign best_len_nxt = larger ? size : best_len_q;
  assign best_r_nxt   = larger ? RW'(cap_r - MW'(size)) : best_r_q;
  assign best_c_nxt   = larger ? CW'(cap_c - MW'(size)) : best_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q     <= '0;
      diag_q     <= '0;
      best_len_q <= '0;
      best_r_q   <= '0;
      best_c_q   <= '0;
    end else if (valid_i) begin
      left_q <= size;
      diag_q <= up;
      if (last_i) begin
        best_len_q <= '0;
        best_r_q   <= '0;
        best_c_q   <= '0;
      end else begin
        best_len_q <= best_len_nxt;
        best_r_q   <= best_r_nxt;
        best_c_q   <= best_c_nxt;
      end
    end
  end

  assign size_o     = size;
  assign push_o     = valid_i && last_i;
  assign res_o.size = SIZE_OUT_W'(best_len_nxt);
  assign res_o.row  = POS_OUT_W'(best_r_nxt);
  assign res_o.col  = POS_OUT_W'(best_c_nxt);

endmodule

[hw/rtl/lesf_res_fifo.sv]
module lesf_res_fifo import lesf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       data_o,
  output logic [1:0] count_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       e0_q, e1_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push_i, pop_i})
      2'b01: begin
        e0_q <= e1_q;
      end
      2'b10: begin
        if (cnt_q == 2'd0) begin
          e0_q <= data_i;
        end else begin
          e1_q <= data_i;
        end
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          e0_q <= data_i;
        end else begin
          e0_q <= e1_q;
          e1_q <= data_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = e0_q;
  assign count_o = cnt_q;

endmodule

[hw/rtl/largest_empty_square_finder_core.sv]
// Channel  | Dir | Handshake               | Beat contents
// ---------+-----+-------------------------+------------------------------------
// in       | in  | in_valid_i / in_ready_o | cell_char_i, last_cell_i
// out      | out | out_valid_o/out_ready_i | best_size_o, best_row_o, best_col_o
// cfg      | in  | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// One cell beat per cycle. The line-buffer read (registered RAM read) is
// launched at the edge that takes a cell, and the size/best update runs in the
// next cycle. The result of a last cell then enters a two-deep output queue:
// it is written from the update stage into the queue and offered from there.
// Input stalls only while the queue, counting a result still in the update
// stage, is full. Reset clears position, best and queue at once; the line
// buffer needs no clearing pass, as a fill count marks the written prefix and
// unwritten entries read as zero.
module largest_empty_square_finder_core import lesf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CHAR_W-1:0]     cell_char_i,
  input  logic                  last_cell_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SIZE_OUT_W-1:0] best_size_o,
  output logic [POS_OUT_W-1:0]  best_row_o,
  output logic [POS_OUT_W-1:0]  best_col_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);

  // configuration registers
  logic [CHAR_W-1:0] obst_q;
  logic [GW_W-1:0]   grid_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_q       <= OBST_RESET;
      grid_width_q <= GW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_OBSTACLE: obst_q       <= cfg_data_i[CHAR_W-1:0];
        CFG_WIDTH:    grid_width_q <= cfg_data_i[GW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  logic       in_accept, pop, push;
  logic [1:0] fifo_cnt;
  logic [2:0] pending;

  // s1 stage
  logic          s1_valid_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_blocked_q, s1_last_q, s1_fwd_q, s1_hit_q;
  logic [SW-1:0] s1_fwd_data_q;

  // results still to be delivered, counting one in the update stage
  assign pop        = out_valid_o && out_ready_i;
  assign pending    = 3'(fifo_cnt) + 3'(s1_valid_q && s1_last_q) - 3'(pop);
  assign in_ready_o = pending < 3'd2;
  assign in_accept  = in_valid_i && in_ready_o;

  // position of the incoming cell
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic          blocked;

  lesf_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_accept),
    .last_i       (last_cell_i),
    .grid_width_i (grid_width_q),
    .col_o        (col_cur),
    .row_o        (row_cur)
  );

  assign blocked = (cell_char_i == obst_q) || (cell_char_i == NEWLINE_CODE) ||
                   (32'(row_cur) >= MAX_HEIGHT);

  // line buffer: written prefix tracked by fill count
  logic [SW-1:0] fill_q;
  logic [SW-1:0] ram_rdata, s1_size;

  lesf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_size),
    .re_i    (in_accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (s1_valid_q && (32'(s1_col_q) >= 32'(fill_q))) begin
      fill_q <= SW'(32'(s1_col_q) + 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  // read of the column being written this edge takes the new value
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q      <= col_cur;
      s1_row_q      <= row_cur;
      s1_blocked_q  <= blocked;
      s1_last_q     <= last_cell_i;
      s1_fwd_q      <= s1_valid_q && (s1_col_q == col_cur);
      s1_fwd_data_q <= s1_size;
      s1_hit_q      <= 32'(col_cur) < 32'(fill_q);
    end
  end

  res_t res_in, res_out;

  lesf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .col_i      (s1_col_q),
    .row_i      (s1_row_q),
    .blocked_i  (s1_blocked_q),
    .last_i     (s1_last_q),
    .ram_data_i (ram_rdata),
    .fwd_i      (s1_fwd_q),
    .fwd_data_i (s1_fwd_data_q),
    .hit_i      (s1_hit_q),
    .size_o     (s1_size),
    .push_o     (push),
    .res_o      (res_in)
  );

  lesf_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (res_out),
    .count_o (fifo_cnt)
  );

  assign best_size_o = res_out.size;
  assign best_row_o  = res_out.row;
  assign best_col_o  = res_out.col;

`ifndef NO_ASSERTIONS
  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fifo_cnt == 2'd2) |-> pop)
    else $error("result queue overflow");

  // an empty result carries a zero corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && best_size_o == '0) |-> (best_row_o == '0 && best_col_o == '0))
    else $error("empty result with non-zero corner");

  // written prefix of the line buffer only grows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q >= $past(fill_q))
    else $error("line buffer fill count shrank");

  // a grid starts at the origin after its last cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_cell_i) |=> (col_cur == '0 && row_cur == '0))
    else $error("position not cleared after last cell");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Largest empty square finder: cell beats stream in row-major order, one result
// beat per grid on the cell marked last. A square tracker mirrors the block's
// dynamic-programming state (line buffer of sides, left/diagonal neighbours,
// position and best square) and queues the square it expects for each grid.
// Result beats are checked field by field against the oldest queued square.
module testbench;
  import lesf_pkg::*;

  // Idle margin for cells still in the pipeline when the last expected
  // result has already come out.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RAND_CELLS    = 300;
  localparam int unsigned RAND_GRIDS    = 30;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned LIMIT_NS      = 5_000_000;

  // Predicts the square of each grid and holds the squares not yet seen.
  class square_tracker;
    int unsigned       up_sides [MAX_WIDTH_DEF];
    int unsigned       left_side, diag_side, col_pos, row_pos;
    int unsigned       best_len, best_r, best_c;
    logic [CHAR_W-1:0] block_code;
    logic [GW_W-1:0]   width_reg;
    res_t              expected_squares [$];
    int unsigned       mismatches, squares_seen;

    function new();
      foreach (up_sides[k]) up_sides[k] = 0;
      clear_grid();
      block_code   = OBST_RESET;
      width_reg    = GW_RESET;
      mismatches   = 0;
      squares_seen = 0;
    endfunction

    function void clear_grid();
      left_side = 0;
      diag_side = 0;
      col_pos   = 0;
      row_pos   = 0;
      best_len  = 0;
      best_r    = 0;
      best_c    = 0;
    endfunction

    function void next_row();
      col_pos   = 0;
      left_side = 0;
      diag_side = 0;
      if (row_pos < MAX_HEIGHT_DEF) row_pos++;
    endfunction

    function int unsigned row_len();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned pending();
      return expected_squares.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OBSTACLE: block_code = data[CHAR_W-1:0];
        CFG_WIDTH:    width_reg  = data[GW_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_cell(logic [CHAR_W-1:0] ch, logic last);
      int unsigned w, col, row, up, side;
      bit          blocked;
      res_t        sq;
      w = row_len();
      // width may have been lowered under a part-filled row
      if (col_pos >= w) next_row();
      col = col_pos;
      row = row_pos;
      blocked = (ch == block_code) || (ch == NEWLINE_CODE) || (row >= MAX_HEIGHT_DEF);
      up = (row == 0) ? 0 : up_sides[col];
      if (col == 0) begin
        left_side = 0;
        diag_side = 0;
      end
      if (blocked) begin
        side = 0;
      end else begin
        side = (up < left_side) ? up : left_side;
        side = ((diag_side < side) ? diag_side : side) + 1;
        // stale line-buffer entries must not grow a square past the grid edge
        if (side > row + 1) side = row + 1;
        if (side > col + 1) side = col + 1;
      end
      up_sides[col] = side;
      diag_side     = up;
      left_side     = side;
      if (side > best_len) begin
        best_len = side;
        best_r   = row + 1 - side;
        best_c   = col + 1 - side;
      end
      col_pos = col + 1;
      if (col_pos >= w) next_row();
      if (last) begin
        sq.size = best_len[SIZE_OUT_W-1:0];
        sq.row  = best_r[POS_OUT_W-1:0];
        sq.col  = best_c[POS_OUT_W-1:0];
        expected_squares.push_back(sq);
        clear_grid();
      end
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_square(res_t got);
      res_t want;
      if (expected_squares.size() == 0) begin
        report($sformatf("result beat size %0d row %0d col %0d with nothing expected",
                         got.size, got.row, got.col));
      end else begin
        want = expected_squares.pop_front();
        squares_seen++;
        if (got.size !== want.size)
          report($sformatf("best_size got %0d want %0d", got.size, want.size));
        if (got.row !== want.row)
          report($sformatf("best_row got %0d want %0d", got.row, want.row));
        if (got.col !== want.col)
          report($sformatf("best_col got %0d want %0d", got.col, want.col));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [CHAR_W-1:0]     cell_char_i;
  logic                  last_cell_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SIZE_OUT_W-1:0] best_size_o;
  logic [POS_OUT_W-1:0]  best_row_o;
  logic [POS_OUT_W-1:0]  best_col_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  square_tracker tracker = new();

  bit          idle_gaps = 1'b1;  // random gaps on both sides
  int unsigned rx_hold_req;       // set to ask the receiver for a long hold-off
  int unsigned rx_hold_left;
  int unsigned cells_sent;

  largest_empty_square_finder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cell_char_i (cell_char_i),
    .last_cell_i (last_cell_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .best_size_o (best_size_o),
    .best_row_o  (best_row_o),
    .best_col_o  (best_col_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every task below is entered at a rising edge and returns at one, so each
  // input gets at most one nonblocking update per edge.

  // Offer one cell beat, possibly after some idle cycles, and hold it until taken.
  task automatic send_cell(logic [CHAR_W-1:0] ch, logic last);
    while (idle_gaps && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cell_char_i <= ch;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_cell(ch, last);
    cells_sent++;
  endtask

  task automatic send_text(string s, bit closes);
    for (int i = 0; i < s.len(); i++) send_cell(s[i], closes && (i == s.len() - 1));
  endtask

  // Sender pauses until every expected square is out and the pipe has emptied.
  task automatic pause_until_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // One random grid at the current width. Mostly whole grids of random
  // density; some end early or run past the nominal height.
  task automatic random_grid();
    int unsigned       w, h, n, dens, pick;
    logic [CHAR_W-1:0] ch;
    w = tracker.row_len();
    h = ($urandom_range(19) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
    n = (w > 32) ? $urandom_range(24, 1) : w * h;
    if ($urandom_range(99) < 15) n = $urandom_range(n + w, 1);
    case ($urandom_range(4))
      0:       dens = 0;
      1:       dens = 10;
      2:       dens = 30;
      3:       dens = 60;
      default: dens = 100;
    endcase
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 2)         ch = NEWLINE_CODE;
      else if (pick < dens) ch = tracker.block_code;
      else                  ch = CHAR_W'($urandom_range(255));
      send_cell(ch, k == n - 1);
    end
  endtask

  // Receiver: checks each result beat at the edge that takes it, then picks
  // ready for the next cycle. A hold-off request is counted down here.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        tracker.check_square('{size: best_size_o, row: best_row_o, col: best_col_o});
      if (rx_hold_req != 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left != 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= !(idle_gaps && $urandom_range(99) < 8);
      end
    end
  end

  initial begin
    int unsigned       grids, first_cell, waited;
    logic [GW_W-1:0]   wv;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cell_char_i <= '0;
    last_cell_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_OBSTACLE;
    cfg_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: 'o' blocks, one row of 1024. Char extremes, newline.
    send_cell(8'd0, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell("o", 1'b0);
    send_cell(NEWLINE_CODE, 1'b0);
    send_cell(".", 1'b1);

    // Obstacle 0 from data with the upper bits set; width 0 acts as 1.
    pause_until_idle();
    write_reg(CFG_OBSTACLE, 11'h700);
    write_reg(CFG_WIDTH, 11'd0);
    send_cell(8'd0, 1'b0);
    send_cell(NEWLINE_CODE, 1'b0);
    send_cell(8'd255, 1'b0);
    send_cell(8'd7, 1'b1);

    // No free cell at all: zero square at the origin.
    pause_until_idle();
    write_reg(CFG_OBSTACLE, 11'h7FF);
    write_reg(CFG_WIDTH, 11'd3);
    send_cell(8'd255, 1'b0);
    send_cell(NEWLINE_CODE, 1'b0);
    send_cell(8'd255, 1'b1);

    // Two equal squares: the first in row-major order must win.
    pause_until_idle();
    write_reg(CFG_OBSTACLE, CFG_DATA_W'("#"));
    write_reg(CFG_WIDTH, 11'd5);
    send_text("ab#cdef#gh", 1'b1);

    // Width lowered under a part-filled row: next cell opens a new row.
    pause_until_idle();
    send_text("abc", 1'b0);
    pause_until_idle();
    write_reg(CFG_WIDTH, 11'd2);
    send_text("de", 1'b1);

    // Width above the maximum acts as the maximum.
    pause_until_idle();
    write_reg(CFG_WIDTH, 11'h7FF);
    send_cell("z", 1'b1);

    // Widest grid, part of the first row: only the tail of it is free.
    pause_until_idle();
    write_reg(CFG_WIDTH, 11'd1024);
    for (int k = 0; k < 20; k++) send_cell((k >= 12) ? "." : "#", k == 19);

    // Receiver holds off for a long stretch while single-cell grids keep
    // coming, so the output queue fills and the input stalls.
    pause_until_idle();
    write_reg(CFG_WIDTH, 11'd4);
    rx_hold_req = 80;
    for (int k = 0; k < 24; k++) send_cell(CHAR_W'($urandom_range(255)), 1'b1);

    // Random grids, with register changes between grids while idle. A run of
    // grids in the middle goes without any idling on either side.
    pause_until_idle();
    grids      = 0;
    first_cell = cells_sent;
    while (cells_sent - first_cell < RAND_CELLS || grids < RAND_GRIDS) begin
      idle_gaps = !(grids >= 12 && grids < 22);
      if ($urandom_range(99) < 30) begin
        pause_until_idle();
        if ($urandom_range(1) == 0) begin
          write_reg(CFG_OBSTACLE, CFG_DATA_W'($urandom_range(2047)));
        end else begin
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
              0:       wv = 11'd0;
              1:       wv = GW_W'($urandom_range(2047, 1024));
              2:       wv = GW_W'($urandom_range(40, 9));
              default: wv = 11'd1;
            endcase
          end else begin
            wv = GW_W'($urandom_range(8, 1));
          end
          write_reg(CFG_WIDTH, wv);
        end
      end
      random_grid();
      grids++;
    end
    idle_gaps = 1'b1;

    // Drain: bounded wait for the outstanding squares, then a short tail to
    // catch any stray result beat.
    in_valid_i <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d expected squares never arrived", tracker.pending()));

    $display("Run: %0d cell beats, %0d squares checked, %0d random grids.",
             cells_sent, tracker.squares_seen, grids);
    $display("Widths 0 to 2047, width cut mid-row, long output hold-off, gapless stretch.");
    if (tracker.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lesf_pkg.sv
hw/rtl/lesf_ram.sv
hw/rtl/lesf_pos.sv
hw/rtl/lesf_dp.sv
hw/rtl/lesf_res_fifo.sv
hw/rtl/largest_empty_square_finder_core.sv
verif/testbench.sv
